[hdl/ndsc_pkg.sv]
// Shared widths, codes and fixed-point helpers for the node damping and slide contact core.
package ndsc_pkg;

  localparam int DW       = 32;
  localparam int FRAC     = 16;
  localparam int TW       = 48;
  localparam int UW       = 31;
  localparam int CFG_IW   = 3;
  localparam int IN_W     = 320;
  localparam int OUT_W    = 264;
  localparam int OUT_USED = 5 * DW + 3 + 2 * TW;
  localparam int MUL_STEP = DW + 1;
  localparam int MUL_LAST = DW + 2;
  localparam int ITER_N   = 32;
  localparam int CW       = 6;

  typedef enum logic [3:0] {
    S_IDLE, S_DCM, S_DFV, S_CMP, S_VERT, S_THR, S_SQX, S_SQY,
    S_SQRT, S_MX, S_DIVX, S_MY, S_DIVY, S_DONE
  } state_t;

  typedef enum logic [CFG_IW-1:0] {
    R_GD    = 3'd0,
    R_DC    = 3'd1,
    R_UZ    = 3'd2,
    R_LZ    = 3'd3,
    R_STIFF = 3'd4,
    R_FC    = 3'd5
  } reg_idx_t;

  function automatic logic [DW-1:0] abs_q(input logic [DW-1:0] x);
    return x[DW-1] ? (~x + 1'b1) : x;
  endfunction

  // product magnitude >> FRAC, clipped, sign applied
  function automatic logic [DW-1:0] mulq_fin(input logic [2*DW:0] p, input logic neg);
    logic [2*DW-FRAC:0] m;
    logic [DW-1:0]      lim;
    logic [DW-1:0]      r;
    m   = p[2*DW:FRAC];
    lim = neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    r   = (m > {{(DW+1-FRAC){1'b0}}, lim}) ? lim : m[DW-1:0];
    return neg ? (~r + 1'b1) : r;
  endfunction

  function automatic logic [DW-1:0] sat_q(input logic [DW:0] s);
    if (s[DW] != s[DW-1]) begin
      return s[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end
    return s[DW-1:0];
  endfunction

  function automatic logic [TW-1:0] sat_t(input logic [TW:0] s);
    if (s[TW] != s[TW-1]) begin
      return s[TW] ? {1'b1, {(TW-1){1'b0}}} : {1'b0, {(TW-1){1'b1}}};
    end
    return s[TW-1:0];
  endfunction

endpackage

[hdl/node_damping_slide_contact_friction_core.sv]
// Top level: node damping, slide contact and friction on a bit-serial sequencer.
//
//  channel  | dir | transfer when          | payload
//  s_axis   | in  | tvalid & tready        | tdata node fields, tuser first_node
//  m_axis   | out | tvalid & tready        | tdata updated forces, flags, totals
//  cfg      | in  | cfg_we                 | cfg_index, cfg_data
//
// Per node: six serial multiplies of damping when gd is clear, then on contact four
// multiplies and a square root, and when the node slides two more multiplies and two
// divisions.
// The shared one-bit-per-cycle multiplier does every product. Reset is synchronous,
// clears the totals and loads register defaults. A stalled result sits in the
// output register while the next node is already being worked on.
module node_damping_slide_contact_friction_core
  import ndsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // node_z, force_x, force_y, force_z, vel_x, vel_y, vel_z, mass_x, mass_y, mass_z
  input  logic [IN_W-1:0]   s_axis_tdata,
  // first_node
  input  logic [0:0]        s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // force_x_out, force_y_out, force_z_out, vel_x_out, vel_y_out, upper, lower, stuck,
  // upper_total, lower_total
  output logic [OUT_W-1:0]  m_axis_tdata,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [DW-1:0]     cfg_data
);

  state_t state, state_next;
  logic [CW-1:0] cnt;
  logic [1:0]    idx;

  logic          gd;
  logic [UW-1:0] dc, stiff, fc;
  logic [DW-1:0] uz, lz;

  logic [DW-1:0] z;
  logic [DW-1:0] f [0:2];
  logic [DW-1:0] v [0:2];
  logic [UW-1:0] m [0:2];

  logic [DW-1:0]   ma, mhi;
  logic [DW:0]     mlo;
  logic [DW-1:0]   cm, vert, thr;
  logic [2*DW-1:0] sq, sr;
  logic [DW:0]     rrem;
  logic [DW-1:0]   root, dr, dq;
  logic            up, low, stuck;
  logic [TW-1:0]   usum, lsum;
  logic            ovalid;
  logic [OUT_W-1:0] odata;

  logic [2*DW:0] prod;
  logic [DW-1:0] op_a, mq, sz, fsel_mag, red;
  logic [DW:0]   op_b, msum, diff, diff_mag;
  logic          op_neg, mul_st, mul_fin, it_fin, up_c, low_c, cont, out_free;
  logic [DW+2:0] rtrial, rcmp;
  logic [DW:0]   dt;
  logic          rge, dge;

  assign prod     = {mhi, mlo};
  assign up_c     = $signed(z) > $signed(uz);
  assign low_c    = $signed(z) < $signed(lz);
  assign cont     = (up_c || low_c) && (stiff != '0);
  assign sz       = low ? lz : uz;
  assign diff     = {sz[DW-1], sz} - {z[DW-1], z};
  assign diff_mag = diff[DW] ? (~diff + 1'b1) : diff;
  assign mul_st   = (state == S_DCM) || (state == S_DFV) || (state == S_VERT) ||
                    (state == S_THR) || (state == S_SQX) || (state == S_SQY) ||
                    (state == S_MX) || (state == S_MY);
  assign mul_fin  = mul_st && (cnt == CW'(MUL_LAST));
  assign it_fin   = cnt == CW'(ITER_N);
  assign msum     = {1'b0, mhi} + (mlo[0] ? {1'b0, ma} : '0);
  assign mq       = mulq_fin(prod, op_neg);
  assign out_free = !ovalid || m_axis_tready;

  assign rtrial = {rrem, sr[2*DW-1:2*DW-2]};
  assign rcmp   = {1'b0, root, 2'b01};
  assign rge    = rtrial >= rcmp;
  assign dt     = {dr, dq[DW-1]};
  assign dge    = dt >= {1'b0, root};

  assign fsel_mag = abs_q((state == S_DIVX) ? f[0] : f[1]);
  assign red      = fsel_mag - ((dq > fsel_mag) ? fsel_mag : dq);

  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_neg = 1'b0;
    case (state)
      S_DCM: begin
        op_a = {1'b0, dc};
        op_b = {2'b0, m[idx]};
      end
      S_DFV: begin
        op_a   = cm;
        op_b   = {1'b0, abs_q(v[idx])};
        op_neg = v[idx][DW-1];
      end
      S_VERT: begin
        op_a   = {1'b0, stiff};
        op_b   = diff_mag;
        op_neg = diff[DW];
      end
      S_THR: begin
        op_a = {1'b0, fc};
        op_b = {1'b0, abs_q(vert)};
      end
      S_SQX: begin
        op_a = abs_q(f[0]);
        op_b = {1'b0, abs_q(f[0])};
      end
      S_SQY: begin
        op_a = abs_q(f[1]);
        op_b = {1'b0, abs_q(f[1])};
      end
      S_MX: begin
        op_a = thr;
        op_b = {1'b0, abs_q(f[0])};
      end
      S_MY: begin
        op_a = thr;
        op_b = {1'b0, abs_q(f[1])};
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (s_axis_tvalid) state_next = gd ? S_CMP : S_DCM;
      S_DCM:  if (mul_fin) state_next = S_DFV;
      S_DFV:  if (mul_fin) state_next = (idx == 2'd2) ? S_CMP : S_DCM;
      S_CMP:  state_next = cont ? S_VERT : S_DONE;
      S_VERT: if (mul_fin) state_next = S_THR;
      S_THR:  if (mul_fin) state_next = S_SQX;
      S_SQX:  if (mul_fin) state_next = S_SQY;
      S_SQY:  if (mul_fin) state_next = S_SQRT;
      S_SQRT: begin
        if (it_fin) state_next = ((root < thr) || (root == '0)) ? S_DONE : S_MX;
      end
      S_MX:   if (mul_fin) state_next = S_DIVX;
      S_DIVX: if (it_fin) state_next = S_MY;
      S_MY:   if (mul_fin) state_next = S_DIVY;
      S_DIVY: if (it_fin) state_next = S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = state == S_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= (state_next != state) ? '0 : cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gd    <= 1'b0;
      dc    <= '0;
      uz    <= {1'b0, {(DW-1){1'b1}}};
      lz    <= {1'b1, {(DW-1){1'b0}}};
      stiff <= '0;
      fc    <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        R_GD:    gd    <= cfg_data[0];
        R_DC:    dc    <= cfg_data[UW-1:0];
        R_UZ:    uz    <= cfg_data;
        R_LZ:    lz    <= cfg_data;
        R_STIFF: stiff <= cfg_data[UW-1:0];
        R_FC:    fc    <= cfg_data[UW-1:0];
        default: ;
      endcase
    end
  end

  // totals and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      usum   <= '0;
      lsum   <= '0;
      ovalid <= 1'b0;
    end else begin
      if (s_axis_tready && s_axis_tvalid && s_axis_tuser[0]) begin
        usum <= '0;
        lsum <= '0;
      end else if (state == S_VERT && mul_fin) begin
        if (up)  usum <= sat_t({usum[TW-1], usum} + {{(TW+1-DW){mq[DW-1]}}, mq});
        if (low) lsum <= sat_t({lsum[TW-1], lsum} + {{(TW+1-DW){mq[DW-1]}}, mq});
      end
      if (state == S_DONE && out_free) begin
        ovalid <= 1'b1;
      end else if (m_axis_tready) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mul_st) begin
      if (cnt == '0) begin
        ma  <= op_a;
        mhi <= '0;
        mlo <= op_b;
      end else if (cnt <= CW'(MUL_STEP)) begin
        mhi <= msum[DW:1];
        mlo <= {msum[0], mlo[DW:1]};
      end
    end

    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          z     <= s_axis_tdata[31:0];
          f[0]  <= s_axis_tdata[63:32];
          f[1]  <= s_axis_tdata[95:64];
          f[2]  <= s_axis_tdata[127:96];
          v[0]  <= s_axis_tdata[159:128];
          v[1]  <= s_axis_tdata[191:160];
          v[2]  <= s_axis_tdata[223:192];
          m[0]  <= s_axis_tdata[254:224];
          m[1]  <= s_axis_tdata[285:255];
          m[2]  <= s_axis_tdata[316:286];
          idx   <= '0;
          stuck <= 1'b0;
        end
      end
      S_DCM: if (mul_fin) cm <= mq;
      S_DFV: begin
        if (mul_fin) begin
          f[idx] <= sat_q({f[idx][DW-1], f[idx]} - {mq[DW-1], mq});
          idx    <= idx + 1'b1;
        end
      end
      S_CMP: begin
        up  <= up_c;
        low <= low_c;
      end
      S_VERT: begin
        if (mul_fin) begin
          vert <= mq;
          f[2] <= sat_q({f[2][DW-1], f[2]} + {mq[DW-1], mq});
        end
      end
      S_THR: if (mul_fin) thr <= mq;
      S_SQX: if (mul_fin) sq <= prod[2*DW-1:0];
      S_SQY: begin
        if (mul_fin) begin
          sr   <= sq + prod[2*DW-1:0];
          rrem <= '0;
          root <= '0;
        end
      end
      S_SQRT: begin
        if (!it_fin) begin
          rrem <= rge ? (DW+1)'(rtrial - rcmp) : rtrial[DW:0];
          root <= {root[DW-2:0], rge};
          sr   <= {sr[2*DW-3:0], 2'b00};
        end else if (root < thr) begin
          stuck <= 1'b1;
          f[0]  <= '0;
          f[1]  <= '0;
          v[0]  <= '0;
          v[1]  <= '0;
        end
      end
      S_MX, S_MY: begin
        if (mul_fin) begin
          dr <= prod[2*DW-1:DW];
          dq <= prod[DW-1:0];
        end
      end
      S_DIVX, S_DIVY: begin
        if (!it_fin) begin
          dr <= dge ? DW'(dt - {1'b0, root}) : dt[DW-1:0];
          dq <= {dq[DW-2:0], dge};
        end else if (state == S_DIVX) begin
          f[0] <= f[0][DW-1] ? (~red + 1'b1) : red;
        end else begin
          f[1] <= f[1][DW-1] ? (~red + 1'b1) : red;
        end
      end
      S_DONE: begin
        if (out_free) begin
          odata <= {{(OUT_W-OUT_USED){1'b0}}, lsum, usum, stuck, low, up,
                    v[1], v[0], f[2], f[1], f[0]};
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = ovalid;
  assign m_axis_tdata  = odata;

endmodule

[hdl/ndsc_checker.sv]
// Port-level checks for the node damping and slide contact core, bound to the top level.
module ndsc_checker
  import ndsc_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_rst_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("not idle after reset");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second node taken while busy");

  a_no_early: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result appeared too early");

endmodule

bind node_damping_slide_contact_friction_core ndsc_checker u_ndsc_checker (.*);
